FILE: design/decimal_number_luma_overlay_defines.svh
// Assertion macros for the decimal number luma overlay checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef DECIMAL_NUMBER_LUMA_OVERLAY_DEFINES_SVH
`define DECIMAL_NUMBER_LUMA_OVERLAY_DEFINES_SVH

// checked only outside reset
`define DNLO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DNLO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/dnlo_pkg.sv
// Package for the decimal number luma overlay: sizes, register indexes,
// sequencer states, the settings bundle and the 6x7 digit font. No dependencies.
`timescale 1ns / 1ps
package dnlo_pkg;

  localparam int DOT_SIZE    = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_STORE = 10;
  localparam int GLYPH_W     = 6;
  localparam int GLYPH_H     = 7;
  localparam int PITCH       = (GLYPH_W + 1) * DOT_SIZE;

  localparam int VALUE_W  = 32;
  localparam int COORD_W  = 12;
  localparam int POS_W    = 13;
  localparam int LUMA_W   = 8;
  localparam int DIG_W    = 4;
  localparam int CNT_W    = 4;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int OFF_W    = (DOT_SIZE > 1) ? $clog2(DOT_SIZE) : 1;
  localparam int WITHIN_W = $clog2(PITCH);
  localparam int BCD_W    = DIGIT_STORE * DIG_W;
  localparam int CONV_W   = $clog2(VALUE_W);
  localparam int KEY_W    = CNT_W + ROW_W + COL_W + 2 * OFF_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [LUMA_W-1:0] INV_THRESH = LUMA_W'(96);
  localparam logic [LUMA_W-1:0] LUMA_MAX   = LUMA_W'(8'hFF);
  localparam logic [LUMA_W-1:0] LUMA_MIN   = '0;

  localparam logic [CFG_IDX_W-1:0] REG_STAMP_VALUE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT        = CFG_IDX_W'(5);

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_CONV,
    SEQ_ALIGN,
    SEQ_SCAN
  } seq_state_t;

  typedef struct packed {
    logic [COORD_W-1:0]                  origin_x;
    logic [COORD_W-1:0]                  origin_y;
    logic [DIGIT_STORE-1:0][DIG_W-1:0]   digits;
    logic [CNT_W-1:0]                    digit_count;
    logic                                abort_valid;
    logic [KEY_W-1:0]                    abort_key;
  } overlay_cfg_t;

  // row masks, bit 5 is the leftmost dot column
  localparam logic [GLYPH_W-1:0] GLYPH_ROM [10][GLYPH_H] = '{
    '{6'h0C, 6'h12, 6'h21, 6'h21, 6'h21, 6'h12, 6'h0C},
    '{6'h04, 6'h04, 6'h04, 6'h04, 6'h04, 6'h04, 6'h04},
    '{6'h3E, 6'h01, 6'h01, 6'h1E, 6'h20, 6'h20, 6'h1F},
    '{6'h3E, 6'h01, 6'h01, 6'h1F, 6'h01, 6'h01, 6'h3E},
    '{6'h11, 6'h11, 6'h11, 6'h1F, 6'h01, 6'h01, 6'h01},
    '{6'h1F, 6'h20, 6'h20, 6'h1E, 6'h01, 6'h01, 6'h3E},
    '{6'h1F, 6'h20, 6'h20, 6'h3E, 6'h21, 6'h21, 6'h1E},
    '{6'h3F, 6'h01, 6'h01, 6'h02, 6'h04, 6'h08, 6'h10},
    '{6'h1F, 6'h21, 6'h21, 6'h1E, 6'h21, 6'h21, 6'h1E},
    '{6'h1F, 6'h21, 6'h21, 6'h1F, 6'h01, 6'h01, 6'h1E}
  };

  function automatic logic [GLYPH_W-1:0] glyph_row(input logic [DIG_W-1:0] digit,
                                                   input logic [ROW_W-1:0] row);
    logic [GLYPH_W-1:0] bits;
    bits = '0;
    if (digit < DIG_W'(10) && row < ROW_W'(GLYPH_H)) begin
      bits = GLYPH_ROM[digit][row];
    end
    return bits;
  endfunction

endpackage

FILE: design/dnlo_if.sv
// Channel interfaces of the decimal number luma overlay: pixel in, result out,
// register writes. Depends on dnlo_pkg.
`timescale 1ns / 1ps
interface dnlo_pixel_if import dnlo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [LUMA_W-1:0]  luma_in;
  modport source (output valid, pixel_x, pixel_y, luma_in, input ready);
  modport sink   (input valid, pixel_x, pixel_y, luma_in, output ready);
endinterface

interface dnlo_result_if import dnlo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] luma_out;
  logic              stamped;
  logic              stamp_aborted;
  modport source (output valid, luma_out, stamped, stamp_aborted, input ready);
  modport sink   (input valid, luma_out, stamped, stamp_aborted, output ready);
endinterface

interface dnlo_cfg_if import dnlo_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VALUE_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/dnlo_ctrl.sv
// Register file and settings sequencer: binary to decimal, digit alignment and
// the dot-by-dot bound scan. Depends on dnlo_pkg and dnlo_cfg_if.
`timescale 1ns / 1ps
module dnlo_ctrl import dnlo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  dnlo_cfg_if.sink     cfg,
  output overlay_cfg_t settings,
  output logic         busy
);

  seq_state_t state, state_next;

  logic [VALUE_W-1:0] stamp_value;
  logic [COORD_W-1:0] origin_x, origin_y, frame_width, frame_height;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd, bcd_adj, bcd_shift, scan_bcd;
  logic [CONV_W-1:0]  conv_cnt;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   sd;
  logic [ROW_W-1:0]   sr;
  logic [COL_W-1:0]   sc;

  logic [DIGIT_STORE-1:0][DIG_W-1:0] digits;
  logic [CNT_W-1:0] digit_count;
  logic             abort_valid;
  logic [KEY_W-1:0] abort_key;

  logic               cfg_wr, shifting, conv_done, lit, bad, last_dot;
  logic [DIG_W-1:0]   scan_digit;
  logic [GLYPH_W-1:0] row_bits;
  logic [POS_W-1:0]   px0, py0, fw, fh;
  logic [OFF_W-1:0]   off_x, off_y;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready && (cfg.index < REG_COUNT);

  always_comb begin
    for (int i = 0; i < DIGIT_STORE; i++) begin
      bcd_adj[i*DIG_W +: DIG_W] = (bcd[i*DIG_W +: DIG_W] >= DIG_W'(5)) ?
                                  bcd[i*DIG_W +: DIG_W] + DIG_W'(3) : bcd[i*DIG_W +: DIG_W];
    end
    bcd_shift = {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
  end

  assign conv_done = (conv_cnt == CONV_W'(VALUE_W - 1));
  assign shifting  = (bcd[BCD_W-1 -: DIG_W] == '0) && (n > CNT_W'(1));

  assign scan_digit = scan_bcd[BCD_W-1 -: DIG_W];
  assign row_bits   = glyph_row(scan_digit, sr);
  assign lit        = row_bits[COL_W'(GLYPH_W - 1) - sc];

  assign px0 = POS_W'(origin_x) + POS_W'(sd * PITCH) + POS_W'(sc * DOT_SIZE);
  assign py0 = POS_W'(origin_y) + POS_W'(sr * DOT_SIZE);
  assign fw  = POS_W'(frame_width);
  assign fh  = POS_W'(frame_height);

  // first failing pixel inside a lit dot: x offset outer, y offset inner
  always_comb begin
    bad   = 1'b0;
    off_x = '0;
    off_y = '0;
    if (px0 > fw || py0 > fh) begin
      bad = 1'b1;
    end else if (py0 + POS_W'(DOT_SIZE - 1) > fh) begin
      bad   = 1'b1;
      off_y = OFF_W'(fh - py0 + POS_W'(1));
    end else if (px0 + POS_W'(DOT_SIZE - 1) > fw) begin
      bad   = 1'b1;
      off_x = OFF_W'(fw - px0 + POS_W'(1));
    end
    bad = bad && lit;
  end

  assign last_dot = (sd == digit_count - CNT_W'(1)) && (sr == ROW_W'(GLYPH_H - 1)) &&
                    (sc == COL_W'(GLYPH_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE:  state_next = SEQ_IDLE;
      SEQ_LOAD:  state_next = SEQ_CONV;
      SEQ_CONV:  if (conv_done) state_next = SEQ_ALIGN;
      SEQ_ALIGN: if (!shifting) state_next = SEQ_SCAN;
      SEQ_SCAN:  if (bad || last_dot) state_next = SEQ_IDLE;
      default:   state_next = SEQ_IDLE;
    endcase
    if (cfg_wr) begin
      state_next = SEQ_LOAD;
    end
  end

  assign busy = (state != SEQ_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_value  <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      frame_width  <= '0;
      frame_height <= '0;
      abort_valid  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg.index)
        REG_STAMP_VALUE:  stamp_value  <= cfg.data;
        REG_ORIGIN_X:     origin_x     <= cfg.data[COORD_W-1:0];
        REG_ORIGIN_Y:     origin_y     <= cfg.data[COORD_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[COORD_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[COORD_W-1:0];
        default: ;
      endcase
    end else begin
      case (state)
        SEQ_LOAD: begin
          abort_valid <= 1'b0;
        end
        SEQ_SCAN: begin
          if (bad) begin
            abort_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SEQ_LOAD: begin
        bin      <= stamp_value;
        bcd      <= '0;
        conv_cnt <= '0;
      end
      SEQ_CONV: begin
        bcd      <= bcd_shift;
        bin      <= bin << 1;
        conv_cnt <= conv_cnt + CONV_W'(1);
        n        <= CNT_W'(DIGIT_STORE);
      end
      SEQ_ALIGN: begin
        if (shifting) begin
          bcd <= bcd << DIG_W;
          n   <= n - CNT_W'(1);
        end else begin
          for (int i = 0; i < DIGIT_STORE; i++) begin
            digits[i] <= bcd[(DIGIT_STORE - 1 - i) * DIG_W +: DIG_W];
          end
          scan_bcd    <= bcd;
          digit_count <= (n > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : n;
          sd <= '0;
          sr <= '0;
          sc <= '0;
        end
      end
      SEQ_SCAN: begin
        if (bad) begin
          abort_key <= {sd, sr, sc, off_x, off_y};
        end else if (sc == COL_W'(GLYPH_W - 1)) begin
          sc <= '0;
          if (sr == ROW_W'(GLYPH_H - 1)) begin
            sr       <= '0;
            sd       <= sd + CNT_W'(1);
            scan_bcd <= scan_bcd << DIG_W;
          end else begin
            sr <= sr + ROW_W'(1);
          end
        end else begin
          sc <= sc + COL_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign settings.origin_x    = origin_x;
  assign settings.origin_y    = origin_y;
  assign settings.digits      = digits;
  assign settings.digit_count = digit_count;
  assign settings.abort_valid = abort_valid;
  assign settings.abort_key   = abort_key;

endmodule

FILE: design/dnlo_pipe.sv
// Four-stage pixel pipeline: offset, digit and row split, column split with
// digit fetch, font lookup and inversion. Depends on dnlo_pkg and the channel interfaces.
`timescale 1ns / 1ps
module dnlo_pipe import dnlo_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  overlay_cfg_t  settings,
  input  logic          busy,
  dnlo_pixel_if.sink    pixel,
  dnlo_result_if.source result
);

  logic advance;
  logic v1, v2, v3, out_valid;

  logic [COORD_W-1:0]  dx1, dy1;
  logic                in1, in2, in3;
  logic [LUMA_W-1:0]   luma1, luma2, luma3;

  logic [CNT_W-1:0]    d_n, d2, d3;
  logic [WITHIN_W-1:0] within_n, within2;
  logic [ROW_W-1:0]    r_n, r2, r3;
  logic [OFF_W-1:0]    yy_n, yy2, yy3;

  logic [COL_W-1:0]    c_n, c3;
  logic [OFF_W-1:0]    xx_n, xx3;
  logic [CNT_W-1:0]    dsel;
  logic [DIG_W-1:0]    digit3;

  logic [GLYPH_W-1:0]  row_bits;
  logic [KEY_W-1:0]    key;
  logic                col_ok, hit;

  logic [LUMA_W-1:0]   luma_out;
  logic                stamped, stamp_aborted;

  assign advance     = !out_valid || result.ready;
  assign pixel.ready = advance && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= pixel.valid && !busy;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // offset from origin
  always_ff @(posedge clk) begin
    if (advance) begin
      in1   <= (pixel.pixel_x >= settings.origin_x) && (pixel.pixel_y >= settings.origin_y);
      dx1   <= pixel.pixel_x - settings.origin_x;
      dy1   <= pixel.pixel_y - settings.origin_y;
      luma1 <= pixel.luma_in;
    end
  end

  // digit index and dot row
  always_comb begin
    d_n      = '0;
    within_n = WITHIN_W'(dx1);
    for (int k = 1; k <= MAX_DIGITS; k++) begin
      if (POS_W'(dx1) >= POS_W'(k * PITCH)) begin
        d_n      = CNT_W'(k);
        within_n = WITHIN_W'(dx1 - COORD_W'(k * PITCH));
      end
    end
    r_n  = '0;
    yy_n = OFF_W'(dy1);
    for (int k = 1; k <= GLYPH_H; k++) begin
      if (POS_W'(dy1) >= POS_W'(k * DOT_SIZE)) begin
        r_n  = ROW_W'(k);
        yy_n = OFF_W'(dy1 - COORD_W'(k * DOT_SIZE));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in2     <= in1;
      luma2   <= luma1;
      d2      <= d_n;
      within2 <= within_n;
      r2      <= r_n;
      yy2     <= yy_n;
    end
  end

  // dot column and digit fetch
  always_comb begin
    c_n  = '0;
    xx_n = OFF_W'(within2);
    for (int k = 1; k <= GLYPH_W; k++) begin
      if (WITHIN_W'(within2) >= WITHIN_W'(k * DOT_SIZE)) begin
        c_n  = COL_W'(k);
        xx_n = OFF_W'(within2 - WITHIN_W'(k * DOT_SIZE));
      end
    end
    dsel = (d2 < CNT_W'(DIGIT_STORE)) ? d2 : '0;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in3    <= in2;
      luma3  <= luma2;
      d3     <= d2;
      r3     <= r2;
      yy3    <= yy2;
      c3     <= c_n;
      xx3    <= xx_n;
      digit3 <= settings.digits[dsel];
    end
  end

  // font lookup and inversion
  always_comb begin
    row_bits = glyph_row(digit3, r3);
    col_ok   = (c3 < COL_W'(GLYPH_W));
    key      = {d3, r3, c3, xx3, yy3};
    hit      = in3 && (d3 < settings.digit_count) && col_ok &&
               row_bits[COL_W'(GLYPH_W - 1) - (col_ok ? c3 : '0)] &&
               (!settings.abort_valid || (key < settings.abort_key));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stamped       <= hit;
      stamp_aborted <= settings.abort_valid;
      if (hit) begin
        luma_out <= (luma3 > INV_THRESH) ? LUMA_MIN : LUMA_MAX;
      end else begin
        luma_out <= luma3;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.luma_out      = luma_out;
  assign result.stamped       = stamped;
  assign result.stamp_aborted = stamp_aborted;

endmodule

FILE: design/decimal_number_luma_overlay.sv
// Top level of the decimal number luma overlay: settings sequencer and pixel
// pipeline. Depends on dnlo_pkg, dnlo_if, dnlo_ctrl and dnlo_pipe.
//
// Takes one pixel word per clock unless stalled or held off, and gives one
// result word per pixel, in order; a stalled result holds the pipeline in
// place. After reset and after every write to registers 0 to 4 the pixel
// input is held off while the settings are rebuilt: a load step, binary to
// decimal conversion and leading-zero removal, then a dot-by-dot bound scan
// of the font (42 dots per digit), which ends at the first lit dot that
// falls out of bounds. Register writes are always taken.
`timescale 1ns / 1ps
module decimal_number_luma_overlay import dnlo_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  dnlo_pixel_if.sink    pixel,
  dnlo_result_if.source result,
  dnlo_cfg_if.sink      cfg
);

  overlay_cfg_t settings;
  logic         busy;

  dnlo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings),
    .busy     (busy)
  );

  dnlo_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .settings (settings),
    .busy     (busy),
    .pixel    (pixel),
    .result   (result)
  );

endmodule

FILE: design/dnlo_checker.sv
// Port-level checks for the decimal number luma overlay, bound to the top level.
// Depends on dnlo_pkg and decimal_number_luma_overlay_defines.svh.
`timescale 1ns / 1ps
`include "decimal_number_luma_overlay_defines.svh"
module dnlo_checker import dnlo_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 pixel_ready,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [LUMA_W-1:0]    luma_out,
  input logic                 stamped
);

  `DNLO_ASSERT(result_hold, result_valid && !result_ready |=> result_valid && $stable(luma_out) && $stable(stamped), "result word changed while stalled")
  `DNLO_ASSERT(stamp_level, result_valid && stamped |-> luma_out == LUMA_MIN || luma_out == LUMA_MAX, "stamped pixel not inverted to black or white")
  `DNLO_ASSERT(write_blocks, cfg_valid && cfg_ready && cfg_index < REG_COUNT |=> !pixel_ready, "pixel taken while settings rebuild")
  `DNLO_ASSERT_ALWAYS(reset_blocks, rst |=> !pixel_ready, "pixel taken straight after reset")

endmodule

bind decimal_number_luma_overlay dnlo_checker u_dnlo_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_ready  (pixel.ready),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .cfg_index    (cfg.index),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .luma_out     (result.luma_out),
  .stamped      (result.stamped)
);

FILE: tb/tb_dnlo_checker.sv
// Scoreboard for the decimal number luma overlay: tracks register writes,
// predicts every result word and compares it. Depends on dnlo_pkg and dnlo_if.
`timescale 1ns / 1ps
module tb_dnlo_checker import dnlo_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  dnlo_pixel_if  pixel,
  dnlo_result_if result,
  dnlo_cfg_if    cfg,
  output int     fail_count,
  output int     pending
);

  localparam int NONE_KEY = 32'hFFFF;

  typedef struct packed {
    logic [LUMA_W-1:0] luma_out;
    logic              stamped;
    logic              stamp_aborted;
  } overlay_word_t;

  logic [VALUE_W-1:0] value_r;
  logic [COORD_W-1:0] ox_r, oy_r, fw_r, fh_r;
  logic [DIG_W-1:0]   digit_r [DIGIT_STORE];
  int                 ndigits;
  int                 stop_key;
  overlay_word_t      expected_q [$];

  function automatic bit lit_dot(int d, int r, int c);
    if (d >= DIGIT_STORE || r >= GLYPH_H || c >= GLYPH_W) return 1'b0;
    return GLYPH_ROM[digit_r[d] % 10][r][GLYPH_W - 1 - c];
  endfunction

  function automatic int dot_key(int d, int r, int c, int xx, int yy);
    return (d << 12) | (r << 9) | (c << 6) | (xx << 3) | yy;
  endfunction

  function automatic void rebuild_layout();
    logic [DIG_W-1:0] rev [DIGIT_STORE];
    logic [VALUE_W-1:0] v;
    int n;
    int px, py;
    v = value_r;
    n = 0;
    do begin
      rev[n] = DIG_W'(v % 10);
      n++;
      v = v / 10;
    end while (v != 0 && n < DIGIT_STORE);
    ndigits = (n < MAX_DIGITS) ? n : MAX_DIGITS;
    for (int i = 0; i < DIGIT_STORE; i++) digit_r[i] = '0;
    for (int i = 0; i < ndigits; i++) digit_r[i] = rev[n - 1 - i];
    stop_key = NONE_KEY;
    for (int d = 0; d < ndigits; d++)
      for (int r = 0; r < GLYPH_H; r++)
        for (int c = 0; c < GLYPH_W; c++) begin
          if (!lit_dot(d, r, c)) continue;
          for (int xx = 0; xx < DOT_SIZE; xx++)
            for (int yy = 0; yy < DOT_SIZE; yy++) begin
              px = ox_r + d * PITCH + c * DOT_SIZE + xx;
              py = oy_r + r * DOT_SIZE + yy;
              if (px > fw_r || py > fh_r) begin
                stop_key = dot_key(d, r, c, xx, yy);
                return;
              end
            end
        end
  endfunction

  function automatic overlay_word_t overlay_pixel(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y,
                                                  logic [LUMA_W-1:0] luma);
    overlay_word_t w;
    int dx, dy, d, wpos, c, r;
    bit hit;
    hit = 1'b0;
    if (x >= ox_r && y >= oy_r) begin
      dx = x - ox_r;
      dy = y - oy_r;
      d = dx / PITCH;
      wpos = dx % PITCH;
      c = wpos / DOT_SIZE;
      r = dy / DOT_SIZE;
      if (d < ndigits && lit_dot(d, r, c) &&
          dot_key(d, r, c, wpos % DOT_SIZE, dy % DOT_SIZE) < stop_key)
        hit = 1'b1;
    end
    w.luma_out = hit ? ((luma > INV_THRESH) ? LUMA_MIN : LUMA_MAX) : luma;
    w.stamped = hit;
    w.stamp_aborted = (stop_key != NONE_KEY);
    return w;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    overlay_word_t got, want;
    if (rst) begin
      value_r = '0;
      ox_r = '0;
      oy_r = '0;
      fw_r = '0;
      fh_r = '0;
      fail_count <= 0;
      expected_q.delete();
      rebuild_layout();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_STAMP_VALUE:  value_r = cfg.data;
          REG_ORIGIN_X:     ox_r = cfg.data[COORD_W-1:0];
          REG_ORIGIN_Y:     oy_r = cfg.data[COORD_W-1:0];
          REG_FRAME_WIDTH:  fw_r = cfg.data[COORD_W-1:0];
          REG_FRAME_HEIGHT: fh_r = cfg.data[COORD_W-1:0];
          default: ;
        endcase
        rebuild_layout();
      end
      if (pixel.valid && pixel.ready)
        expected_q.push_back(overlay_pixel(pixel.pixel_x, pixel.pixel_y, pixel.luma_in));
      if (result.valid && result.ready) begin
        got = '{result.luma_out, result.stamped, result.stamp_aborted};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
// Top of the decimal number luma overlay testbench: clock, reset, stimulus
// and verdict. Depends on dnlo_pkg, dnlo_if, the block and tb_dnlo_checker.
`timescale 1ns / 1ps
module tb_top import dnlo_pkg::*;;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   choke_req;
  int   quiet_cycles;

  dnlo_pixel_if  pixel ();
  dnlo_result_if result ();
  dnlo_cfg_if    cfg ();

  decimal_number_luma_overlay u_top (
    .clk(clk), .rst(rst), .pixel(pixel), .result(result), .cfg(cfg)
  );

  tb_dnlo_checker u_checker (
    .clk(clk), .rst(rst), .pixel(pixel), .result(result), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    result.ready = 1'b0;
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        repeat (200) begin
          result.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel.valid && pixel.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [LUMA_W-1:0] luma);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel.valid <= 1'b0;
      @(posedge clk);
    end
    pixel.valid <= 1'b1;
    pixel.pixel_x <= x;
    pixel.pixel_y <= y;
    pixel.luma_in <= luma;
    @(posedge clk);
    while (!pixel.ready) @(posedge clk);
  endtask

  task automatic drain();
    pixel.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return VALUE_W'($urandom_range(0, 999));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 12'hFFF;
      default: return COORD_W'($urandom_range(0, 600));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_bound(logic [COORD_W-1:0] o);
    case ($urandom_range(0, 3))
      0: return 12'hFFF;
      1: return '0;
      default: return COORD_W'(o + $urandom_range(0, 300));
    endcase
  endfunction

  logic [COORD_W-1:0] ox, oy;
  logic [VALUE_W-1:0] val;

  initial begin
    rst = 1'b1;
    choke_req = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 70;
    pixel.valid = 1'b0;
    pixel.pixel_x = '0;
    pixel.pixel_y = '0;
    pixel.luma_in = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: a zero with a zero-sized frame
    send_pixel(12'd2, 12'd0, 8'd200);
    send_pixel(12'd0, 12'd0, 8'd50);
    drain();

    // a single "1" at (100,100)
    write_reg(REG_STAMP_VALUE, 32'd1);
    write_reg(REG_ORIGIN_X, 32'd100);
    write_reg(REG_ORIGIN_Y, 32'd100);
    write_reg(REG_FRAME_WIDTH, 32'hFFF);
    write_reg(REG_FRAME_HEIGHT, 32'hFFF);
    send_pixel(12'd112, 12'd100, 8'd0);
    send_pixel(12'd113, 12'd101, 8'd255);
    send_pixel(12'd114, 12'd102, 8'd96);
    send_pixel(12'd115, 12'd103, 8'd97);
    send_pixel(12'd111, 12'd100, 8'd97);
    send_pixel(12'd124, 12'd104, 8'd10);
    send_pixel(12'd112, 12'd128, 8'd10);
    send_pixel(12'd99, 12'd100, 8'd10);
    send_pixel(12'd112, 12'd99, 8'd10);
    send_pixel(12'd0, 12'd0, 8'd255);
    send_pixel(12'hFFF, 12'hFFF, 8'd0);
    drain();

    // ten digits, clipped by the frame within the first digit
    write_reg(REG_STAMP_VALUE, 32'hFFFF_FFFF);
    write_reg(REG_ORIGIN_X, 32'd0);
    write_reg(REG_ORIGIN_Y, 32'd0);
    write_reg(REG_FRAME_WIDTH, 32'd150);
    write_reg(REG_FRAME_HEIGHT, 32'd20);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'd0);
    for (int i = 0; i < 8; i++)
      send_pixel(COORD_W'($urandom_range(0, 290)), COORD_W'($urandom_range(0, 27)),
                 LUMA_W'($urandom));
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 17;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      val = pick_value();
      ox = pick_coord();
      oy = pick_coord();
      write_reg(REG_STAMP_VALUE, val);
      write_reg(REG_ORIGIN_X, VALUE_W'(ox));
      write_reg(REG_ORIGIN_Y, VALUE_W'(oy));
      write_reg(REG_FRAME_WIDTH, VALUE_W'(pick_bound(ox)));
      write_reg(REG_FRAME_HEIGHT, VALUE_W'(pick_bound(oy)));
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), VALUE_W'($urandom));
      if (ph == 9) choke_req = 1'b1;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 9) < 8)
          send_pixel(COORD_W'(ox + $urandom_range(0, 290)),
                     COORD_W'(oy + $urandom_range(0, 31)), LUMA_W'($urandom));
        else
          send_pixel(COORD_W'($urandom), COORD_W'($urandom), LUMA_W'($urandom));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
